### rtl/ava_pkg.sv
// shared types, constants and lookup functions of the averaging voltmeter
package ava_pkg;

    localparam int SAMPLE_W = 10;
    localparam int AVG_W    = 10;
    localparam int TENTHS_W = 6;
    localparam int SEG_W    = 7;
    localparam int BCD_W    = 8;

    localparam logic FUNC_SAMPLE  = 1'b0;
    localparam logic FUNC_REFRESH = 1'b1;

    // (avg * 33 + 511) / 1023 as one multiply by a rounded-up reciprocal of 1023
    localparam int SCALE_SHIFT = 26;
    localparam int SCALE_K_W   = 22;
    localparam int SCALE_P_W   = 33;
    localparam logic [SCALE_K_W-1:0] SCALE_MUL  = SCALE_K_W'(33 * 65601);
    localparam logic [SCALE_P_W-1:0] SCALE_BIAS = SCALE_P_W'(511 * 65601);

    typedef struct packed {
        logic valid;
        logic func;
        logic done;
    } t_ctl;

    function automatic logic [SEG_W-1:0] seg_code(input logic [3:0] d);
        logic [SEG_W-1:0] s;
        case (d)
            4'd0:    s = 7'h3F;
            4'd1:    s = 7'h06;
            4'd2:    s = 7'h5B;
            4'd3:    s = 7'h4F;
            4'd4:    s = 7'h66;
            4'd5:    s = 7'h6D;
            4'd6:    s = 7'h7D;
            4'd7:    s = 7'h07;
            4'd8:    s = 7'h7F;
            4'd9:    s = 7'h6F;
            4'd10:   s = 7'h77;
            4'd11:   s = 7'h7C;
            4'd12:   s = 7'h39;
            4'd13:   s = 7'h5E;
            4'd14:   s = 7'h79;
            default: s = 7'h71;
        endcase
        return s;
    endfunction

    // value stays below 40, so the tens digit is found by three compares
    function automatic logic [BCD_W-1:0] to_bcd(input logic [TENTHS_W-1:0] v);
        logic [3:0] tens;
        logic [TENTHS_W-1:0] units;
        if (v >= TENTHS_W'(30)) begin
            tens  = 4'd3;
            units = v - TENTHS_W'(30);
        end else if (v >= TENTHS_W'(20)) begin
            tens  = 4'd2;
            units = v - TENTHS_W'(20);
        end else if (v >= TENTHS_W'(10)) begin
            tens  = 4'd1;
            units = v - TENTHS_W'(10);
        end else begin
            tens  = 4'd0;
            units = v;
        end
        return {tens, units[3:0]};
    endfunction

endpackage

### rtl/ava_in_if.sv
// input channel: sample or refresh item
interface ava_in_if;
    import ava_pkg::*;

    logic                valid;
    logic                ready;
    logic                func;
    logic [SAMPLE_W-1:0] sample;

    modport source (output valid, output func, output sample, input ready);
    modport sink   (input valid, input func, input sample, output ready);
endinterface

### rtl/ava_out_if.sv
// output channel: selected digit and its segment code
interface ava_out_if;
    import ava_pkg::*;

    logic             valid;
    logic             ready;
    logic             digit_select;
    logic [SEG_W-1:0] segments;

    modport source (output valid, output digit_select, output segments, input ready);
    modport sink   (input valid, input digit_select, input segments, output ready);
endinterface

### rtl/ava_accum.sv
// input register and running sample accumulator
module ava_accum #(
    parameter int SAMPLES_PER_AVERAGE = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    ava_in_if.sink               i_in,
    input  logic                 i_ready_b,
    output ava_pkg::t_ctl        o_b,
    output logic [$clog2(SAMPLES_PER_AVERAGE*1023+1)-1:0] o_b_sum
);
    import ava_pkg::*;

    localparam int SUM_W = $clog2(SAMPLES_PER_AVERAGE * 1023 + 1);
    localparam int CNT_W = $clog2(SAMPLES_PER_AVERAGE);
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(SAMPLES_PER_AVERAGE - 1);

    logic                r_a_valid;
    logic                r_a_func;
    logic [SAMPLE_W-1:0] r_a_sample;
    t_ctl                r_b;
    logic [SUM_W-1:0]    r_b_sum;
    logic [SUM_W-1:0]    r_sum;
    logic [CNT_W-1:0]    r_count;

    logic [SUM_W-1:0] n_sum;
    logic             last;
    logic             load_b;
    logic             adv_a;

    assign n_sum  = r_sum + SUM_W'(r_a_sample);
    assign last   = (r_count == LAST_CNT);
    assign load_b = !r_b.valid || i_ready_b;
    assign adv_a  = r_a_valid && load_b;

    assign i_in.ready = !r_a_valid || load_b;
    assign o_b        = r_b;
    assign o_b_sum    = r_b_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b       <= '0;
            r_sum     <= '0;
            r_count   <= '0;
        end else begin
            if (i_in.ready) begin
                r_a_valid <= i_in.valid;
            end
            if (load_b) begin
                r_b.valid <= r_a_valid;
                r_b.func  <= r_a_func;
                r_b.done  <= (r_a_func == FUNC_SAMPLE) && last;
            end
            if (adv_a && r_a_func == FUNC_SAMPLE) begin
                if (last) begin
                    r_sum   <= '0;
                    r_count <= '0;
                end else begin
                    r_sum   <= n_sum;
                    r_count <= r_count + CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready) begin
            r_a_func   <= i_in.func;
            r_a_sample <= i_in.sample;
        end
        if (load_b) begin
            r_b_sum <= n_sum;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= LAST_CNT)
        else $error("sample count beyond group size");

    a_done_on_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b.valid && r_b.done |-> r_b.func == FUNC_SAMPLE)
        else $error("group end flagged on a refresh item");

endmodule

### rtl/ava_scale.sv
// average by reciprocal multiply, then scaling to tenths of a volt
module ava_scale #(
    parameter int SAMPLES_PER_AVERAGE = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  ava_pkg::t_ctl        i_b,
    input  logic [$clog2(SAMPLES_PER_AVERAGE*1023+1)-1:0] i_b_sum,
    output logic                 o_ready_b,
    input  logic                 i_ready_d,
    output ava_pkg::t_ctl        o_d,
    output logic [ava_pkg::TENTHS_W-1:0] o_d_tenths
);
    import ava_pkg::*;

    localparam int SUM_W   = $clog2(SAMPLES_PER_AVERAGE * 1023 + 1);
    localparam int RSHIFT  = SUM_W + $clog2(SAMPLES_PER_AVERAGE);
    localparam int PROD_W  = SUM_W + RSHIFT;
    localparam logic [RSHIFT-1:0] RECIP =
        RSHIFT'((2 ** RSHIFT + SAMPLES_PER_AVERAGE - 1) / SAMPLES_PER_AVERAGE);

    t_ctl                r_c;
    logic [AVG_W-1:0]    r_c_avg;
    t_ctl                r_d;
    logic [TENTHS_W-1:0] r_d_tenths;

    logic [PROD_W-1:0]    avg_prod;
    logic [SCALE_P_W-1:0] scale_prod;
    logic                 load_c;
    logic                 load_d;

    assign avg_prod   = {{RSHIFT{1'b0}}, i_b_sum} * {{SUM_W{1'b0}}, RECIP};
    assign scale_prod = {{(SCALE_P_W - AVG_W){1'b0}}, r_c_avg}
                        * {{(SCALE_P_W - SCALE_K_W){1'b0}}, SCALE_MUL} + SCALE_BIAS;

    assign load_d    = !r_d.valid || i_ready_d;
    assign load_c    = !r_c.valid || load_d;
    assign o_ready_b = load_c;
    assign o_d        = r_d;
    assign o_d_tenths = r_d_tenths;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c <= '0;
            r_d <= '0;
        end else begin
            if (load_c) begin
                r_c <= i_b;
            end
            if (load_d) begin
                r_d <= r_c;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_c) begin
            r_c_avg <= avg_prod[RSHIFT +: AVG_W];
        end
        if (load_d) begin
            r_d_tenths <= scale_prod[SCALE_SHIFT +: TENTHS_W];
        end
    end

    a_tenths_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_d.valid && r_d.done |-> r_d_tenths <= TENTHS_W'(33))
        else $error("scaled reading above full scale");

endmodule

### rtl/ava_disp.sv
// digit store, digit multiplexing and segment output register
module ava_disp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  ava_pkg::t_ctl                 i_d,
    input  logic [ava_pkg::TENTHS_W-1:0]  i_d_tenths,
    output logic                          o_ready_d,
    ava_out_if.source                     o_out
);
    import ava_pkg::*;

    logic             r_o_valid;
    logic             r_o_sel;
    logic [SEG_W-1:0] r_o_seg;
    logic [BCD_W-1:0] r_bcd;
    logic             r_turn;

    logic       load_e;
    logic       take;
    logic [3:0] digit;

    assign load_e    = !r_o_valid || o_out.ready;
    assign o_ready_d = (i_d.func == FUNC_SAMPLE) || load_e;
    assign take      = i_d.valid && o_ready_d;
    assign digit     = r_turn ? r_bcd[7:4] : r_bcd[3:0];

    assign o_out.valid        = r_o_valid;
    assign o_out.digit_select = r_o_sel;
    assign o_out.segments     = r_o_seg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
            r_bcd     <= '0;
            r_turn    <= 1'b0;
        end else begin
            if (take && i_d.func == FUNC_REFRESH) begin
                r_o_valid <= 1'b1;
                r_turn    <= ~r_turn;
            end else if (o_out.ready) begin
                r_o_valid <= 1'b0;
            end
            if (take && i_d.func == FUNC_SAMPLE && i_d.done) begin
                r_bcd <= to_bcd(i_d_tenths);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && i_d.func == FUNC_REFRESH) begin
            r_o_sel <= r_turn;
            r_o_seg <= seg_code(digit);
        end
    end

    a_bcd_digits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bcd[7:4] <= 4'd3 && r_bcd[3:0] <= 4'd9)
        else $error("stored digits out of range");

    a_turn_toggle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take && i_d.func == FUNC_REFRESH |=> r_turn != $past(r_turn) && r_o_valid)
        else $error("refresh did not switch digit");

endmodule

### rtl/adc_average_voltmeter_display.sv
// top level of the averaging voltmeter with two-digit display
// One item is accepted per clock cycle unless stalled, and each takes five register stages from
// transfer to the output register: input register and accumulator, average by
// reciprocal multiply, scaling multiply, then digit store and segment register.
// Ready is chained back through the stage valids, so bubbles are filled while a
// result waits and the throughput is one item per cycle while the output side
// keeps taking results. Sample items give no output; the average of each group
// of SAMPLES_PER_AVERAGE readings shows on refresh items that follow the group's
// last sample, and each refresh item gives one digit, units first.
module adc_average_voltmeter_display #(
    parameter int SAMPLES_PER_AVERAGE = 8
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ava_in_if.sink    i_in,
    ava_out_if.source o_out
);
    import ava_pkg::*;

    localparam int SUM_W = $clog2(SAMPLES_PER_AVERAGE * 1023 + 1);

    t_ctl                ctl_b;
    logic [SUM_W-1:0]    sum_b;
    logic                ready_b;
    t_ctl                ctl_d;
    logic [TENTHS_W-1:0] tenths_d;
    logic                ready_d;

    ava_accum #(
        .SAMPLES_PER_AVERAGE(SAMPLES_PER_AVERAGE)
    ) u_accum (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .i_ready_b (ready_b),
        .o_b       (ctl_b),
        .o_b_sum   (sum_b)
    );

    ava_scale #(
        .SAMPLES_PER_AVERAGE(SAMPLES_PER_AVERAGE)
    ) u_scale (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_b        (ctl_b),
        .i_b_sum    (sum_b),
        .o_ready_b  (ready_b),
        .i_ready_d  (ready_d),
        .o_d        (ctl_d),
        .o_d_tenths (tenths_d)
    );

    ava_disp u_disp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_d        (ctl_d),
        .i_d_tenths (tenths_d),
        .o_ready_d  (ready_d),
        .o_out      (o_out)
    );

endmodule
